FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define RTDI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RTDI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/rtdi_pkg.sv
// ----------------------------------------------------------------------------
// rtdi_pkg
// Shared types and constants of the ready-to-drive interlock.
// ----------------------------------------------------------------------------
package rtdi_pkg;

    localparam int unsigned DEB_W      = 4;
    localparam int unsigned THR_W      = 12;
    localparam int unsigned DUR_W      = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned NUM_SIG    = 3;

    localparam int unsigned SIG_SWITCH = 0;
    localparam int unsigned SIG_MOTOR  = 1;
    localparam int unsigned SIG_BRAKE  = 2;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DEB_W-1:0] DEBOUNCE_RST  = DEB_W'(3);
    localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(1000);
    localparam logic [DUR_W-1:0] DURATION_RST  = DUR_W'(2000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_DURATION  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [DEB_W-1:0] debounce_readings;
        logic [THR_W-1:0] brake_threshold;
        logic [DUR_W-1:0] buzz_time_ms;
    } cfg_t;

    // Classified tick: active-high readings plus timestamp
    typedef struct packed {
        logic [NUM_SIG-1:0] reading;
        logic [TIME_W-1:0]  now_ms;
    } tick_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: rtl/rtdi_if.sv
// ----------------------------------------------------------------------------
// rtdi_if
// Valid/ready channels for input ticks and result words.
// ----------------------------------------------------------------------------
interface rtdi_tick_if;
    import rtdi_pkg::*;

    logic                valid;
    logic                ready;
    logic                start_switch_pin;
    logic                motor_active_pin;
    logic [THR_W-1:0]    brake_sample;
    logic                sample_valid;
    logic [TIME_W-1:0]   now_ms;

    modport source (
        output valid, start_switch_pin, motor_active_pin, brake_sample, sample_valid, now_ms,
        input  ready
    );
    modport sink (
        input  valid, start_switch_pin, motor_active_pin, brake_sample, sample_valid, now_ms,
        output ready
    );
endinterface

interface rtdi_result_if;
    logic valid;
    logic ready;
    logic start_switch_on;
    logic motor_active;
    logic brake_pressed;
    logic ready_to_drive;
    logic buzzer_on;

    modport source (
        output valid, start_switch_on, motor_active, brake_pressed, ready_to_drive, buzzer_on,
        input  ready
    );
    modport sink (
        input  valid, start_switch_on, motor_active, brake_pressed, ready_to_drive, buzzer_on,
        output ready
    );
    modport mon (
        input valid, ready, start_switch_on, motor_active, brake_pressed, ready_to_drive,
        buzzer_on
    );
endinterface

FILE: rtl/rtdi_front.sv
// ----------------------------------------------------------------------------
// rtdi_front
// Takes raw ticks and turns them into active-high readings for the queue.
// ----------------------------------------------------------------------------
module rtdi_front (
    rtdi_tick_if.sink           ticks,
    input  rtdi_pkg::cfg_t      cfg,
    input  rtdi_pkg::q_status_t q_status,
    output logic                push,
    output rtdi_pkg::tick_t     word
);
    import rtdi_pkg::*;

    assign ticks.ready = !q_status.full;
    assign push        = ticks.valid && !q_status.full;

    always_comb
    begin
        word.reading[SIG_SWITCH] = !ticks.start_switch_pin;
        word.reading[SIG_MOTOR]  = !ticks.motor_active_pin;
        // failed conversion never counts as pressed
        word.reading[SIG_BRAKE]  = ticks.sample_valid
                                   && (ticks.brake_sample > cfg.brake_threshold);
        word.now_ms              = ticks.now_ms;
    end

endmodule

FILE: rtl/rtdi_queue.sv
// ----------------------------------------------------------------------------
// rtdi_queue
// Short FIFO between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module rtdi_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rtdi_pkg::tick_t     wr_word,
    input  logic                pop,
    output rtdi_pkg::tick_t     rd_word,
    output rtdi_pkg::q_status_t status
);
    import rtdi_pkg::*;

    tick_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign rd_word      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/rtdi_back.sv
// ----------------------------------------------------------------------------
// rtdi_back
// Debounce filters and the idle/buzzer/ready sequencer; owns the result slot.
// ----------------------------------------------------------------------------
module rtdi_back (
    input  logic                clk,
    input  logic                rst_n,
    input  rtdi_pkg::cfg_t      cfg,
    input  rtdi_pkg::q_status_t q_status,
    input  rtdi_pkg::tick_t     word,
    output logic                pop,
    rtdi_result_if.source       results
);
    import rtdi_pkg::*;

    typedef enum logic [1:0] {
        SEQ_IDLE   = 2'd0,
        SEQ_BUZZER = 2'd2,
        SEQ_READY  = 2'd3
    } seq_state_t;

    seq_state_t         state_reg;
    seq_state_t         state_next;
    logic [NUM_SIG-1:0] level_reg;
    logic [NUM_SIG-1:0] level_next;
    logic [DEB_W-1:0]   count_reg [NUM_SIG];
    logic [DEB_W-1:0]   count_next [NUM_SIG];
    logic [TIME_W-1:0]  start_ms_reg;
    logic [TIME_W-1:0]  start_ms_next;
    logic               buzzer_reg;
    logic               buzzer_next;
    logic               ready_reg;
    logic               ready_next;
    logic               out_valid_reg;
    logic [TIME_W-1:0]  elapsed;
    logic               all_on;

    // state regs only move on pop, so they double as the result payload
    assign pop               = !q_status.empty && (!out_valid_reg || results.ready);
    assign results.valid           = out_valid_reg;
    assign results.start_switch_on = level_reg[SIG_SWITCH];
    assign results.motor_active    = level_reg[SIG_MOTOR];
    assign results.brake_pressed   = level_reg[SIG_BRAKE];
    assign results.ready_to_drive  = ready_reg;
    assign results.buzzer_on       = buzzer_reg;

    always_comb
    begin
        logic [DEB_W:0] n;
        for (int i = 0; i < NUM_SIG; i++)
        begin
            n             = {1'b0, count_reg[i]} + 1'b1;
            level_next[i] = level_reg[i];
            count_next[i] = '0;
            if (word.reading[i] != level_reg[i])
            begin
                // a setting of zero acts like one
                if (n >= {1'b0, cfg.debounce_readings})
                begin
                    level_next[i] = word.reading[i];
                end
                else
                begin
                    count_next[i] = n[DEB_W-1:0];
                end
            end
        end
    end

    assign all_on  = &level_next;
    assign elapsed = word.now_ms - start_ms_reg;

    always_comb
    begin
        state_next    = state_reg;
        start_ms_next = start_ms_reg;
        buzzer_next   = buzzer_reg;
        ready_next    = ready_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                ready_next = 1'b0;
                if (all_on)
                begin
                    buzzer_next   = 1'b1;
                    start_ms_next = word.now_ms;
                    state_next    = SEQ_BUZZER;
                end
            end
            SEQ_BUZZER:
            begin
                if (elapsed >= {{(TIME_W - DUR_W){1'b0}}, cfg.buzz_time_ms})
                begin
                    buzzer_next = 1'b0;
                    ready_next  = 1'b1;
                    state_next  = SEQ_READY;
                end
                else if (!all_on)
                begin
                    buzzer_next = 1'b0;
                    ready_next  = 1'b0;
                    state_next  = SEQ_IDLE;
                end
            end
            SEQ_READY:
            begin
                if (!level_next[SIG_MOTOR] || !level_next[SIG_SWITCH])
                begin
                    ready_next = 1'b0;
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                buzzer_next = 1'b0;
                ready_next  = 1'b0;
                state_next  = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            level_reg     <= '0;
            count_reg     <= '{default: '0};
            start_ms_reg  <= '0;
            buzzer_reg    <= 1'b0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                state_reg     <= state_next;
                level_reg     <= level_next;
                count_reg     <= count_next;
                start_ms_reg  <= start_ms_next;
                buzzer_reg    <= buzzer_next;
                ready_reg     <= ready_next;
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/ready_to_drive_interlock.sv
// ----------------------------------------------------------------------------
// ready_to_drive_interlock
// Debounced start/motor/brake inputs driving an idle-buzzer-ready sequencer.
// ----------------------------------------------------------------------------
// Takes one tick word per clock while the queue has room and returns one
// result word per tick, in order. A tick is classified as it is accepted and
// written into a two-entry queue; the sequencer pops one word per cycle when
// its result slot is empty or being drained, so a result is held in a queue
// entry, then in the result registers. Throughput is one word per clock while
// results are taken. Registers are written through cfg_we, cfg_index, cfg_data
// only with no tick in flight (user's duty, unchecked); index 3 is ignored.
// ----------------------------------------------------------------------------
module ready_to_drive_interlock (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rtdi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rtdi_pkg::CFG_DATA_W-1:0]     cfg_data,
    rtdi_tick_if.sink                           ticks,
    rtdi_result_if.source                       results
);
    import rtdi_pkg::*;

    cfg_t      cfg_reg;
    q_status_t q_status;
    tick_t     push_word;
    tick_t     pop_word;
    logic      push;
    logic      pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_readings <= DEBOUNCE_RST;
            cfg_reg.brake_threshold   <= THRESHOLD_RST;
            cfg_reg.buzz_time_ms      <= DURATION_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE:  cfg_reg.debounce_readings <= cfg_data[DEB_W-1:0];
                CFG_THRESHOLD: cfg_reg.brake_threshold   <= cfg_data[THR_W-1:0];
                CFG_DURATION:  cfg_reg.buzz_time_ms      <= cfg_data[DUR_W-1:0];
                default:       ;
            endcase
        end
    end

    rtdi_front u_front (
        .ticks    (ticks),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .push     (push),
        .word     (push_word)
    );

    rtdi_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_word (push_word),
        .pop     (pop),
        .rd_word (pop_word),
        .status  (q_status)
    );

    rtdi_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .word     (pop_word),
        .pop      (pop),
        .results  (results)
    );

endmodule

FILE: rtl/rtdi_checker.sv
// ----------------------------------------------------------------------------
// rtdi_checker
// Port-level checks on the result channel of the interlock.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtdi_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic res_valid,
    input  logic res_ready,
    input  logic res_sw,
    input  logic res_mot,
    input  logic res_brk,
    input  logic res_rtd,
    input  logic res_buzz
);

    logic [4:0] res_word;
    logic       all_in_on;

    assign res_word  = {res_sw, res_mot, res_brk, res_rtd, res_buzz};
    assign all_in_on = res_sw && res_mot && res_brk;

    // nothing is offered while held in reset
    `RTDI_ASSERT_ALWAYS(a_no_valid_in_reset, clk, !rst_n |-> !res_valid, "valid during reset")

    `RTDI_ASSERT(a_stall_holds, clk, rst_n,
        res_valid && !res_ready |=> res_valid && $stable(res_word),
        "result word changed while stalled")

    // buzzer only sounds with all three inputs on, and never together with ready
    `RTDI_ASSERT(a_buzzer_needs_all, clk, rst_n,
        res_valid && res_buzz |-> all_in_on && !res_rtd, "buzzer without all inputs on")

    // ready is only reached from the buzzer phase
    `RTDI_ASSERT(a_ready_after_buzzer, clk, rst_n, $rose(res_rtd) |-> $past(res_buzz),
        "ready without buzzer")

endmodule

bind ready_to_drive_interlock rtdi_checker u_rtdi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_sw    (results.start_switch_on),
    .res_mot   (results.motor_active),
    .res_brk   (results.brake_pressed),
    .res_rtd   (results.ready_to_drive),
    .res_buzz  (results.buzzer_on)
);
